### sv/sliding_window_singleton_count_assert.svh
// assertion macros for the sliding window singleton counter
// used by the top level, which supplies clk and arst_n in scope
`ifndef SLIDING_WINDOW_SINGLETON_COUNT_ASSERT_SVH
`define SLIDING_WINDOW_SINGLETON_COUNT_ASSERT_SVH

// condition holds in the same cycle as the trigger
`define SWSC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// condition holds in the cycle after the trigger
`define SWSC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### sv/swsc_pkg.sv
// shared constants, types and helpers for the sliding window singleton counter
// no dependencies
package swsc_pkg;

	localparam int VALUE_COUNT = 1024;
	localparam int VAL_W       = $clog2(VALUE_COUNT);
	localparam int WINDOW_MAX  = 64;
	localparam int LEN_W       = $clog2(WINDOW_MAX + 1);
	localparam int PTR_W       = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
	localparam int CNT_W       = LEN_W;
	localparam int GROUP       = 8;
	localparam int GROUPS      = (WINDOW_MAX + GROUP - 1) / GROUP;
	localparam int PART_W      = $clog2(GROUP + 1);
	localparam int FIFO_DEPTH  = 4;
	localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_W  = $clog2(FIFO_DEPTH + 1);
	localparam int INFL_W      = 2;

	localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(4);

	// register word index
	localparam logic REG_WINDOW_LEN = 1'b0;

	// broadcast to every window cell
	typedef struct packed {
		logic             shift;
		logic [VAL_W-1:0] add_val;
		logic [VAL_W-1:0] ret_val;
	} cell_ctl_t;

	// per-request tag carried through the counting pipeline
	typedef struct packed {
		logic valid;
		logic emit;
		logic full;
		logic same;
	} tally_tag_t;

	function automatic logic [PART_W-1:0] popcount_group(input logic [GROUP-1:0] bits);
		logic [PART_W-1:0] sum;
		sum = '0;
		for (int k = 0; k < GROUP; k++) begin
			sum = sum + PART_W'(bits[k]);
		end
		return sum;
	endfunction

endpackage

### sv/swsc_cell.sv
// one window cell: holds a value, shifts it on, compares it to the broadcast values
// depends on swsc_pkg
module swsc_cell (
	input  logic                      clk,
	input  swsc_pkg::cell_ctl_t       ctl,
	input  logic [swsc_pkg::VAL_W-1:0] din,
	input  logic                      in_win,
	input  logic                      is_last,
	output logic [swsc_pkg::VAL_W-1:0] value,
	output logic                      match_add,
	output logic                      match_ret,
	output logic [swsc_pkg::VAL_W-1:0] tap
);
	import swsc_pkg::*;

	logic [VAL_W-1:0] value_q;

	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			value_q <= din;
		end
	end

	assign value     = value_q;
	assign match_add = in_win && (value_q == ctl.add_val);
	assign match_ret = in_win && (value_q == ctl.ret_val);
	// only the oldest cell of the window drives the retire bus
	assign tap       = is_last ? value_q : '0;

endmodule

### sv/swsc_tally.sv
// match counting pipeline and running singleton total
// depends on swsc_pkg
module swsc_tally (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           clear,
	input  swsc_pkg::tally_tag_t           tag,
	input  logic [swsc_pkg::WINDOW_MAX-1:0] match_add,
	input  logic [swsc_pkg::WINDOW_MAX-1:0] match_ret,
	output logic                           push,
	output logic [swsc_pkg::CNT_W-1:0]     push_data,
	output logic [swsc_pkg::INFL_W-1:0]    inflight
);
	import swsc_pkg::*;

	localparam int PAD_W = GROUPS * GROUP;

	tally_tag_t             tag_s1, tag_s2;
	logic [PAD_W-1:0]       ma_s1, mr_s1;
	logic [PART_W-1:0]      pa_s2 [GROUPS];
	logic [PART_W-1:0]      pr_s2 [GROUPS];
	logic [CNT_W-1:0]       total_q;
	logic [CNT_W-1:0]       cnt_add, cnt_ret, cnt_add_left, total_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
			tag_s2 <= '0;
		end else begin
			tag_s1 <= tag;
			tag_s2 <= tag_s1;
		end
	end

	always_ff @(posedge clk) begin
		ma_s1 <= PAD_W'(match_add);
		mr_s1 <= PAD_W'(match_ret);
		for (int g = 0; g < GROUPS; g++) begin
			pa_s2[g] <= popcount_group(ma_s1[g*GROUP +: GROUP]);
			pr_s2[g] <= popcount_group(mr_s1[g*GROUP +: GROUP]);
		end
	end

	always_comb begin
		cnt_add = '0;
		cnt_ret = '0;
		for (int g = 0; g < GROUPS; g++) begin
			cnt_add = cnt_add + CNT_W'(pa_s2[g]);
			cnt_ret = cnt_ret + CNT_W'(pr_s2[g]);
		end
		// occurrences of the new value once the oldest one has left
		cnt_add_left = cnt_add - CNT_W'(tag_s2.same);
		total_nxt = total_q;
		if (tag_s2.full) begin
			if (cnt_ret == CNT_W'(1)) begin
				total_nxt = total_nxt - CNT_W'(1);
			end else if (cnt_ret == CNT_W'(2)) begin
				total_nxt = total_nxt + CNT_W'(1);
			end
		end
		if (cnt_add_left == '0) begin
			total_nxt = total_nxt + CNT_W'(1);
		end else if (cnt_add_left == CNT_W'(1)) begin
			total_nxt = total_nxt - CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
		end else if (clear) begin
			total_q <= '0;
		end else if (tag_s2.valid) begin
			total_q <= total_nxt;
		end
	end

	assign push      = tag_s2.valid && tag_s2.emit;
	assign push_data = total_nxt;
	assign inflight  = INFL_W'(tag_s1.valid) + INFL_W'(tag_s2.valid);

endmodule

### sv/swsc_fifo.sv
// small result queue that decouples the counting pipeline from the receiver
// depends on swsc_pkg
module swsc_fifo (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            push,
	input  logic [swsc_pkg::CNT_W-1:0]      push_data,
	input  logic                            pop_ready,
	output logic                            pop_valid,
	output logic [swsc_pkg::CNT_W-1:0]      pop_data,
	output logic [swsc_pkg::FIFO_CNT_W-1:0] count
);
	import swsc_pkg::*;

	logic [CNT_W-1:0]      mem [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [FIFO_CNT_W-1:0] cnt_q;
	logic                  pop;

	assign pop = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + FIFO_PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + FIFO_PTR_W'(1);
			end
			cnt_q <= cnt_q + FIFO_CNT_W'(push) - FIFO_CNT_W'(pop);
		end
	end

	assign pop_valid = (cnt_q != '0);
	assign pop_data  = mem[rd_ptr_q];
	assign count     = cnt_q;

endmodule

### sv/sliding_window_singleton_count.sv
// Sliding window singleton counter.
// Input stream s_*: one value per request in s_tdata; a request is taken when
// s_tvalid and s_tready are high. The last window_len values form the window, and
// once it is full every request yields on m_* the number of values that occur
// exactly once in it; the first window_len-1 requests after reset or a register
// write yield nothing.
// The window is a row of 64 cells that shift on every request; each cell compares
// its value against the new value and the value being retired, and the match
// vectors are counted in a two-stage registered adder tree.
// Throughput: one request per cycle while s_tready is high. The result is registered
// through the two counting stages and the result queue before it reaches m_tdata.
// A four-entry result queue sits before m_*; s_tready drops while the queue plus
// the requests still in the counting stages would fill it, so a stalled receiver
// backs up into the input after at most four results.
// APB register 0 (address 0) is window_len; a write restarts the stream.
// Reset clears the window, the total and the queue, and sets window_len to 4; no
// clearing pass is needed, so requests are taken from the first cycle.
// depends on swsc_pkg, swsc_cell, swsc_tally, swsc_fifo and the assertion header
module sliding_window_singleton_count (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [9:0] item_value
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [6:0] singleton_count
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import swsc_pkg::*;

	logic [LEN_W-1:0]      len_raw_q, len_eff_q, fill_q;
	logic [PTR_W-1:0]      len_m1;
	logic                  cfg_wr, acc, full, emit;
	logic [VAL_W-1:0]      add_val, ret_val;
	cell_ctl_t             ctl;
	tally_tag_t            tag;
	logic [VAL_W-1:0]      cell_val [WINDOW_MAX];
	logic [VAL_W-1:0]      cell_tap [WINDOW_MAX];
	logic [WINDOW_MAX-1:0] match_add, match_ret, in_win, is_last;
	logic                  push, pop_valid;
	logic [CNT_W-1:0]      push_data, pop_data;
	logic [INFL_W-1:0]     inflight;
	logic [FIFO_CNT_W-1:0] fifo_cnt;
	logic [LEN_W-1:0]      wr_len;

	// register port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_WINDOW_LEN);
	assign wr_len = pwdata[LEN_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_raw_q <= LEN_RESET;
			len_eff_q <= LEN_RESET;
		end else if (cfg_wr) begin
			len_raw_q <= wr_len;
			if (wr_len == '0) begin
				len_eff_q <= LEN_W'(1);
			end else if (wr_len > LEN_W'(WINDOW_MAX)) begin
				len_eff_q <= LEN_W'(WINDOW_MAX);
			end else begin
				len_eff_q <= wr_len;
			end
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_WINDOW_LEN) begin
			prdata = 32'(len_raw_q);
		end
	end

	// window fill and request control
	assign acc     = s_tvalid && s_tready;
	assign full    = (fill_q == len_eff_q);
	assign emit    = full || ((fill_q + LEN_W'(1)) == len_eff_q);
	assign len_m1  = PTR_W'(len_eff_q - LEN_W'(1));
	assign add_val = s_tdata[VAL_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (cfg_wr) begin
			fill_q <= '0;
		end else if (acc && !full) begin
			fill_q <= fill_q + LEN_W'(1);
		end
	end

	always_comb begin
		ret_val = '0;
		for (int i = 0; i < WINDOW_MAX; i++) begin
			ret_val = ret_val | cell_tap[i];
		end
	end

	assign ctl.shift   = acc;
	assign ctl.add_val = add_val;
	assign ctl.ret_val = ret_val;

	assign tag.valid = acc;
	assign tag.emit  = emit;
	assign tag.full  = full;
	assign tag.same  = full && (ret_val == add_val);

	// row of window cells, newest in cell 0
	for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
		logic [VAL_W-1:0] din;
		if (i == 0) begin : g_head
			assign din = add_val;
		end else begin : g_body
			assign din = cell_val[i-1];
		end
		assign in_win[i]  = (LEN_W'(i) < fill_q);
		assign is_last[i] = (len_m1 == PTR_W'(i));
		swsc_cell u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.din       (din),
			.in_win    (in_win[i]),
			.is_last   (is_last[i]),
			.value     (cell_val[i]),
			.match_add (match_add[i]),
			.match_ret (match_ret[i]),
			.tap       (cell_tap[i])
		);
	end

	swsc_tally u_tally (
		.clk       (clk),
		.arst_n    (arst_n),
		.clear     (cfg_wr),
		.tag       (tag),
		.match_add (match_add),
		.match_ret (match_ret),
		.push      (push),
		.push_data (push_data),
		.inflight  (inflight)
	);

	swsc_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop_ready (m_tready),
		.pop_valid (pop_valid),
		.pop_data  (pop_data),
		.count     (fifo_cnt)
	);

	// room for every request that could still land in the queue
	assign s_tready = ((INFL_W + 1)'(fifo_cnt) + (INFL_W + 1)'(inflight))
		< (INFL_W + 1)'(FIFO_DEPTH);

	assign m_tvalid = pop_valid;
	assign m_tdata  = 8'(pop_data);

	`include "sliding_window_singleton_count_assert.svh"

	`SWSC_ASSERT_NOW(a_fill_bound, 1'b1, (fill_q <= len_eff_q) && (len_eff_q != '0), "fill level beyond window length")
	`SWSC_ASSERT_NEXT(a_accept_tracked, acc, inflight != '0, "accepted request lost before counting")
	`SWSC_ASSERT_NOW(a_queue_room, push, (fifo_cnt < FIFO_CNT_W'(FIFO_DEPTH)) || (pop_valid && m_tready), "result queue overflow")

endmodule

### tb/swsc_checker.sv
`timescale 1ns / 100ps
// checker for sliding_window_singleton_count: tracks the window per accepted request
// and compares each result and each window_len readback; depends on swsc_pkg
module swsc_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [15:0] s_tdata,   // [9:0] item_value
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [7:0]  m_tdata,   // [6:0] singleton_count
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic [31:0] prdata,
	input  logic        pready,
	output int          pending,
	output int          failures
);
	import swsc_pkg::*;

	logic [LEN_W-1:0] len_setting;
	logic [VAL_W-1:0] ring_vals [WINDOW_MAX];
	logic [CNT_W-1:0] occur [VALUE_COUNT];
	logic [CNT_W-1:0] once_total;
	logic [LEN_W-1:0] held;
	logic [PTR_W-1:0] head_slot;
	logic [CNT_W-1:0] count_due [$];

	function automatic int span();
		if (len_setting == '0) return 1;
		if (len_setting > WINDOW_MAX) return WINDOW_MAX;
		return int'(len_setting);
	endfunction

	task automatic restart_window();
		foreach (occur[i]) occur[i] = '0;
		foreach (ring_vals[i]) ring_vals[i] = '0;
		once_total = '0;
		held = '0;
		head_slot = '0;
	endtask

	task automatic tally_in(input logic [VAL_W-1:0] v);
		occur[v] = occur[v] + 1'b1;
		if (occur[v] == 1) once_total = once_total + 1'b1;
		else if (occur[v] == 2 && once_total != 0) once_total = once_total - 1'b1;
	endtask

	task automatic tally_out(input logic [VAL_W-1:0] v);
		if (occur[v] == 0) return;
		if (occur[v] == 1 && once_total != 0) once_total = once_total - 1'b1;
		occur[v] = occur[v] - 1'b1;
		if (occur[v] == 1) once_total = once_total + 1'b1;
	endtask

	// one accepted value: fill while short of the window, else retire oldest then add
	task automatic take_value(input logic [VAL_W-1:0] v);
		int n;
		int slot;
		n = span();
		if (int'(held) < n) begin
			ring_vals[PTR_W'(held)] = v;
			tally_in(v);
			held = held + 1'b1;
			if (int'(held) == n) count_due.push_back(once_total);
		end else begin
			slot = int'(head_slot) % n;
			tally_out(ring_vals[PTR_W'(slot)]);
			ring_vals[PTR_W'(slot)] = v;
			tally_in(v);
			head_slot = PTR_W'((slot + 1) % n);
			count_due.push_back(once_total);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		logic [CNT_W-1:0] want;
		if (!arst_n) begin
			len_setting = LEN_RESET;
			restart_window();
			count_due.delete();
			failures = 0;
		end else begin
			if (psel && penable && pready && paddr[2] == REG_WINDOW_LEN) begin
				if (pwrite) begin
					len_setting = pwdata[LEN_W-1:0];
					restart_window();
				end else if (prdata !== 32'(len_setting)) begin
					$error("window_len: expected %0d, got %0d", len_setting, prdata);
					failures++;
				end
			end
			if (s_tvalid && s_tready) take_value(s_tdata[VAL_W-1:0]);
			if (m_tvalid && m_tready) begin
				if (count_due.size() == 0) begin
					$error("singleton_count: expected none, got %0d", m_tdata[CNT_W-1:0]);
					failures++;
				end else begin
					want = count_due.pop_front();
					if (m_tdata[CNT_W-1:0] !== want) begin
						$error("singleton_count: expected %0d, got %0d",
							want, m_tdata[CNT_W-1:0]);
						failures++;
					end
				end
			end
		end
		pending = count_due.size();
	end

endmodule

### tb/tb.sv
`timescale 1ns / 100ps
// top of the testbench for sliding_window_singleton_count: clock, reset, value stream,
// window_len writes and the verdict; depends on swsc_pkg and swsc_checker
module tb;
	import swsc_pkg::*;

	localparam logic [2:0] ADDR_WINDOW_LEN = {REG_WINDOW_LEN, 2'b00};
	localparam logic [2:0] ADDR_UNMAPPED   = {~REG_WINDOW_LEN, 2'b00};
	localparam int RANDOM_ITEMS = 1530;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int HOLD_CYCLES  = 300;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	int pending;
	int failures;
	int cycles = 0;
	bit steady = 1'b0;
	bit rx_hold_req = 1'b0;
	bit hold_served = 1'b0;

	logic [VAL_W-1:0] opening [16] = '{
		10'd0, 10'd1023, 10'd0, 10'd1023, 10'd682, 10'd341, 10'd1023, 10'd0,
		10'd5, 10'd5, 10'd5, 10'd5, 10'd512, 10'd511, 10'd1, 10'd1022
	};

	sliding_window_singleton_count DUT (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	swsc_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.pending(pending), .failures(failures)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	// result side: random single-cycle stalls, one long hold-off when asked
	initial begin
		forever begin
			@(negedge clk);
			if (rx_hold_req && !hold_served) begin
				hold_served = 1'b1;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			if (!steady && $urandom_range(0, 99) < 9) m_tready <= 1'b0;
			else m_tready <= 1'b1;
		end
	end

	// entered and left at a falling edge
	task automatic push_value(input logic [VAL_W-1:0] v);
		if (!steady && $urandom_range(0, 99) < 9) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= 16'(v);
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic apb_access(input logic wr, input logic [2:0] addr, input logic [31:0] data);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= addr;
		pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// drain all results, give the pipeline time to settle, then write and read back
	task automatic reconfigure(input logic [2:0] addr, input logic [31:0] data);
		s_tvalid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (8) @(negedge clk);
		apb_access(1'b1, addr, data);
		apb_access(1'b0, ADDR_WINDOW_LEN, '0);
	endtask

	initial begin
		logic [LEN_W-1:0] len_w;
		int n_eff;
		int n_items;
		int alpha;
		int base;
		int v;
		int phase;
		int done_items;

		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		apb_access(1'b0, ADDR_WINDOW_LEN, '0);

		// reset window of four: extremes, duplicates, every bit
		foreach (opening[i]) push_value(opening[i]);
		reconfigure(ADDR_WINDOW_LEN, 32'd1);
		push_value(10'd1023);
		push_value(10'd0);
		push_value(10'd1023);
		// zero length behaves as one
		reconfigure(ADDR_WINDOW_LEN, 32'd0);
		push_value(10'd0);
		push_value(10'd0);
		// write to an unmapped address must leave the stream alone
		reconfigure(ADDR_UNMAPPED, 32'd5);
		push_value(10'd1023);
		push_value(10'd512);

		phase = 0;
		done_items = 0;
		while (done_items < RANDOM_ITEMS) begin
			case (phase)
				0: len_w = 7'd127;
				1: len_w = 7'd65;
				2: len_w = 7'd64;
				3: len_w = 7'd2;
				4: len_w = 7'd3;
				5: len_w = 7'd1;
				default: begin
					if ($urandom_range(0, 6) == 0) len_w = 7'($urandom_range(0, 127));
					else len_w = 7'($urandom_range(1, 64));
				end
			endcase
			reconfigure(ADDR_WINDOW_LEN, 32'(len_w));
			n_eff = (len_w == 0) ? 1 : (len_w > WINDOW_MAX) ? WINDOW_MAX : int'(len_w);
			steady = (phase == 1);
			rx_hold_req = (phase == 2);
			n_items = n_eff + $urandom_range(16, 96);
			alpha = $urandom_range(1, 2 * n_eff + 2);
			base = $urandom_range(0, 1023);
			for (int i = 0; i < n_items; i++) begin
				// first phase keeps the full window distinct to reach the top count
				if (phase == 0) v = base + i * 11;
				else if ($urandom_range(0, 3) == 0) v = $urandom_range(0, 1023);
				else v = base + $urandom_range(0, alpha - 1);
				push_value(VAL_W'(v));
			end
			done_items += n_items;
			phase++;
		end

		s_tvalid <= 1'b0;
		steady = 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (10) @(negedge clk);
		if (failures == 0) $display("end of test: clean");
		else $display("end of test: mismatches");
		$finish;
	end

endmodule
